@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that is checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

@@ src/asca_pkg.sv @@
package asca_pkg;

    // Sizing of the averager.
    localparam int CHANNELS    = 16;
    localparam int SAMPLES     = 8;
    localparam int SAMPLE_BITS = 10;

    // Fixed field widths of the ports.
    localparam int MASK_BITS  = 16;
    localparam int OP_BITS    = 2;
    localparam int CHAN_BITS  = 4;
    localparam int VALUE_BITS = 10;
    localparam int OUT_BITS   = 10;

    // Derived widths.
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int POS_W      = $clog2(CHANNELS + 1);
    localparam int SLOT_W     = $clog2(SAMPLES);
    localparam int HIST_DEPTH = CHANNELS * SAMPLES;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int SUM_W      = SAMPLE_BITS + SLOT_W;

    typedef enum logic [OP_BITS-1:0] {
        OP_SAMPLE = 2'd0,
        OP_PRESET = 2'd1,
        OP_READ   = 2'd2,
        OP_POLL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Outcome of the scan search for the next conversion.
    typedef struct packed {
        logic            found;
        logic            last;
        logic [CH_W-1:0] ch;
    } t_scan_pick;

    typedef struct packed {
        logic [CHAN_BITS-1:0] channel_out;
        logic [OUT_BITS-1:0]  average;
        logic [OUT_BITS-1:0]  sample_echo;
        logic                 channel_valid;
        logic                 batch_done;
    } t_result;

endpackage

@@ src/asca_ifs.sv @@
interface asca_in_if;
    import asca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    op;
    logic [CHAN_BITS-1:0]  channel;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output op, output channel, output value, input ready);
    modport sink   (input valid, input op, input channel, input value, output ready);
endinterface

interface asca_out_if;
    import asca_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] channel_out;
    logic [OUT_BITS-1:0]  average;
    logic [OUT_BITS-1:0]  sample_echo;
    logic                 channel_valid;
    logic                 batch_done;

    modport source (output valid, output channel_out, output average, output sample_echo,
                    output channel_valid, output batch_done, input ready);
    modport sink   (input valid, input channel_out, input average, input sample_echo,
                    input channel_valid, input batch_done, output ready);
endinterface

@@ src/adc_scan_channel_averager_unit.sv @@
// ADC scan channel averager. Each conversion beat is filed under the next
// enabled channel of the mask, in ascending channel order, into an 8-deep
// history per channel with a running sum, so a read beat returns the channel's
// truncated boxcar mean (zero for a disabled channel). All channels share one
// sample slot, which advances after the highest enabled channel is filed; when
// it wraps, the sample's result reports batch done and a sticky flag is set,
// which a poll beat returns and clears. A preset beat writes one value into
// every history entry and the matching sum into every channel. The history
// and the sums live in two synchronous memories with a registered read. The
// block works on one beat at a time: a conversion, read or poll beat is taken,
// its result is written to the output register once that register is free,
// and no new beat is taken before then. A preset walks all 128 history
// entries, one per cycle, and finishes once its result can be loaded into the
// output register. After reset the same walk clears both memories, so input
// ready stays low until the walk is done.
// The mask register may be written only while the block is idle.
`include "assert_macros.svh"

module adc_scan_channel_averager_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [asca_pkg::MASK_BITS-1:0] i_cfg_wdata,
    asca_in_if.sink                        i_in,
    asca_out_if.source                     o_out
);
    import asca_pkg::*;

    localparam logic [HIST_AW-1:0] SWEEP_LAST = HIST_AW'(HIST_DEPTH - 1);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SAMPLES - 1);

    // Sample history, channel-major, and one running sum per channel.
    logic [SAMPLE_BITS-1:0] mem_hist [HIST_DEPTH];
    logic [SUM_W-1:0]       mem_sum  [CHANNELS];

    t_state                 r_state;
    t_state                 n_state;
    logic [MASK_BITS-1:0]   r_mask;
    logic [POS_W-1:0]       r_scan_pos;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_batch_flag;
    logic [HIST_AW-1:0]     r_sweep_idx;
    logic [SAMPLE_BITS-1:0] r_fill;
    logic                   r_sweep_reply;

    // Beat held while it is worked on.
    t_op                    r_op;
    logic [SAMPLE_BITS-1:0] r_val;
    logic [CH_W-1:0]        r_chan;
    logic                   r_found;
    logic                   r_last;
    logic                   r_read_en;
    logic [HIST_AW-1:0]     r_hist_addr;
    logic [SAMPLE_BITS-1:0] r_hist_q;
    logic [SUM_W-1:0]       r_sum_q;

    logic                   r_out_valid;
    t_result                r_out;
    t_result                n_result;

    t_scan_pick             w_pick;
    t_op                    w_in_op;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_commit;
    logic                   w_sweep_done;
    logic                   w_load;
    logic                   w_wrap;
    logic [HIST_AW-1:0]     w_hist_raddr;
    logic [CH_W-1:0]        w_sum_raddr;
    logic                   w_hist_we;
    logic [HIST_AW-1:0]     w_hist_waddr;
    logic [SAMPLE_BITS-1:0] w_hist_wdata;
    logic                   w_sum_we;
    logic [CH_W-1:0]        w_sum_waddr;
    logic [SUM_W-1:0]       w_sum_wdata;
    logic [SUM_W-1:0]       w_new_sum;

    asca_scan u_scan (
        .i_mask (r_mask[CHANNELS-1:0]),
        .i_pos  (r_scan_pos),
        .o_pick (w_pick)
    );

    assign w_in_op    = t_op'(i_in.op);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == ST_EXEC) && w_out_free;
    assign w_sweep_done = (r_state == ST_SWEEP) && (r_sweep_idx == SWEEP_LAST)
                          && (!r_sweep_reply || w_out_free);
    assign w_load     = w_commit || (w_sweep_done && r_sweep_reply);

    // The slot wraps when the last enabled channel takes the last slot.
    assign w_wrap = (r_op == OP_SAMPLE) && r_found && r_last && (r_slot == SLOT_LAST);

    // Drop the replaced sample from the sum and add the new one.
    assign w_new_sum = r_sum_q - SUM_W'(r_hist_q) + SUM_W'(r_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_op == OP_PRESET) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (w_sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake, memory ports and the result of the beat being finished.
    always_comb begin
        i_in.ready   = (r_state == ST_IDLE);
        w_hist_raddr = {w_pick.ch, r_slot};
        w_sum_raddr  = (w_in_op == OP_READ) ? i_in.channel[CH_W-1:0] : w_pick.ch;

        w_hist_we    = 1'b0;
        w_hist_waddr = r_hist_addr;
        w_hist_wdata = r_val;
        w_sum_we     = 1'b0;
        w_sum_waddr  = r_chan;
        w_sum_wdata  = w_new_sum;
        n_result     = '0;

        case (r_state)
            ST_SWEEP: begin
                // One history entry a cycle; a channel's sum on its first entry.
                w_hist_we    = 1'b1;
                w_hist_waddr = r_sweep_idx;
                w_hist_wdata = r_fill;
                w_sum_we     = (r_sweep_idx[SLOT_W-1:0] == '0);
                w_sum_waddr  = r_sweep_idx[HIST_AW-1:SLOT_W];
                w_sum_wdata  = SUM_W'(r_fill) << SLOT_W;
            end
            ST_EXEC: begin
                case (r_op)
                    OP_SAMPLE: begin
                        if (r_found) begin
                            w_hist_we              = w_commit;
                            w_sum_we               = w_commit;
                            n_result.channel_out   = CHAN_BITS'(r_chan);
                            n_result.sample_echo   = OUT_BITS'(r_val);
                            n_result.channel_valid = 1'b1;
                            n_result.batch_done    = w_wrap;
                        end
                    end
                    OP_READ: begin
                        n_result.channel_out = CHAN_BITS'(r_chan);
                        if (r_read_en) begin
                            n_result.average = OUT_BITS'(r_sum_q >> SLOT_W);
                        end
                    end
                    OP_POLL: begin
                        n_result.batch_done = r_batch_flag;
                    end
                    default: begin
                        n_result = '0;
                    end
                endcase
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            mem_hist[w_hist_waddr] <= w_hist_wdata;
        end
        if (w_accept) begin
            r_hist_q <= mem_hist[w_hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            mem_sum[w_sum_waddr] <= w_sum_wdata;
        end
        if (w_accept) begin
            r_sum_q <= mem_sum[w_sum_raddr];
        end
    end

    // Captured beat and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= w_in_op;
            r_val       <= i_in.value[SAMPLE_BITS-1:0];
            r_chan      <= (w_in_op == OP_READ) ? i_in.channel[CH_W-1:0] : w_pick.ch;
            r_found     <= w_pick.found;
            r_last      <= w_pick.last;
            r_read_en   <= r_mask[i_in.channel[CH_W-1:0]];
            r_hist_addr <= w_hist_raddr;
        end
        if (w_load) begin
            r_out <= n_result;
        end
    end

    // Control state. Reset starts a sweep of zeros that clears both memories.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_mask        <= '0;
            r_scan_pos    <= '0;
            r_slot        <= '0;
            r_batch_flag  <= 1'b0;
            r_sweep_idx   <= '0;
            r_fill        <= '0;
            r_sweep_reply <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_sweep_idx   <= '0;
                r_fill        <= i_in.value[SAMPLE_BITS-1:0];
                r_sweep_reply <= 1'b1;
            end else if ((r_state == ST_SWEEP) && (r_sweep_idx != SWEEP_LAST)) begin
                r_sweep_idx <= r_sweep_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && (r_op == OP_SAMPLE) && r_found) begin
                if (r_last) begin
                    r_scan_pos <= '0;
                    r_slot     <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                    if (w_wrap) begin
                        r_batch_flag <= 1'b1;
                    end
                end else begin
                    r_scan_pos <= POS_W'(r_chan) + 1'b1;
                end
            end
            if (w_commit && (r_op == OP_POLL)) begin
                r_batch_flag <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.channel_out   = r_out.channel_out;
    assign o_out.average       = r_out.average;
    assign o_out.sample_echo   = r_out.sample_echo;
    assign o_out.channel_valid = r_out.channel_valid;
    assign o_out.batch_done    = r_out.batch_done;

    // A taken beat always leaves the idle state for work.
    `ASSERT_CLKRST(a_accept_starts_work, i_clk, i_rst_n,
        (w_accept |=> (r_state != ST_IDLE)), "accepted beat did not start work")
    // The sweep walks the history one entry per cycle without stopping early.
    `ASSERT_CLKRST(a_sweep_steps, i_clk, i_rst_n,
        (((r_state == ST_SWEEP) && (r_sweep_idx != SWEEP_LAST)) |=>
         ((r_state == ST_SWEEP) && (r_sweep_idx == $past(r_sweep_idx) + 1'b1))),
        "sweep did not advance")
    // A slot wrap must leave the batch flag set.
    `ASSERT_CLKRST(a_wrap_sets_flag, i_clk, i_rst_n,
        ((w_commit && w_wrap) |=> r_batch_flag), "slot wrap lost batch flag")
    // Memories are written only while a beat or the sweep is in progress.
    `ASSERT_CLKRST(a_write_when_busy, i_clk, i_rst_n,
        ((w_hist_we || w_sum_we) |-> (r_state != ST_IDLE)), "memory write while idle")

endmodule

@@ src/asca_scan.sv @@
module asca_scan (
    input  logic [asca_pkg::CHANNELS-1:0] i_mask,
    input  logic [asca_pkg::POS_W-1:0]    i_pos,
    output asca_pkg::t_scan_pick          o_pick
);
    import asca_pkg::*;

    logic [CHANNELS-1:0] w_above;
    logic [CHANNELS-1:0] w_cand;
    logic [CH_W-1:0]     w_ch;
    logic                w_higher;

    // Enabled channels at or above the scan position; fall back to the whole
    // mask when the scan has run past the last one.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_above[c] = i_mask[c] && (POS_W'(c) >= i_pos);
        end
        w_cand = (|w_above) ? w_above : i_mask;
    end

    always_comb begin
        w_ch = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (w_cand[c]) begin
                w_ch = CH_W'(c);
            end
        end
    end

    always_comb begin
        w_higher = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_mask[c] && (CH_W'(c) > w_ch)) begin
                w_higher = 1'b1;
            end
        end
    end

    assign o_pick.found = |i_mask;
    assign o_pick.last  = !w_higher;
    assign o_pick.ch    = w_ch;

endmodule

@@ verif/tb.sv @@
// Testbench for the ADC scan channel averager.
//
// A small tracker class follows the block beat by beat. It keeps its own
// copy of the sample history, the per-channel sums, the shared sample slot,
// the scan position, the sticky batch flag and the enable mask. Every input
// beat accepted at a rising edge is run through it, and the result it owes
// is queued. Every result beat accepted at a rising edge is then compared,
// field by field, with the oldest owed result.
//
// The run has three parts. A short directed part covers the no-channel case,
// reads of disabled channels, a full-scale preset, a mask change in the
// middle of a scan and a batch wrap followed by two polls. After that come
// eight random phases, each under its own mask, including the all-on, single
// channel and all-off masks. Inputs change at the falling edge and outputs
// are sampled at the rising edge, so no check depends on event order.
module tb;
    import asca_pkg::*;

    // The beats of all phases with their gaps and the rare preset walk fit far
    // below this, even with the clearing walk after reset.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BEATS  = 100;
    localparam int SETTLE_TICKS = 16;

    // Follows the averager's state and holds the results it still owes.
    class boxcar_tracker;
        logic [SAMPLE_BITS-1:0] hist [HIST_DEPTH];
        logic [SUM_W-1:0]       sums [CHANNELS];
        int unsigned            slot;
        int unsigned            scan_pos;
        bit                     batch_flag;
        logic [MASK_BITS-1:0]   mask;
        t_result                owed_results[$];
        int                     mismatches;

        function new();
            foreach (hist[i]) hist[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            slot       = 0;
            scan_pos   = 0;
            batch_flag = 0;
            mask       = '0;
            mismatches = 0;
        endfunction

        function void set_mask(logic [MASK_BITS-1:0] m);
            mask = m;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        // Lowest enabled channel at or above start, CHANNELS if there is none.
        function int unsigned first_enabled(int unsigned start);
            for (int unsigned c = start; c < CHANNELS; c++) begin
                if (mask[c]) return c;
            end
            return CHANNELS;
        endfunction

        function void take_beat(t_op op, logic [CHAN_BITS-1:0] chan,
                                logic [VALUE_BITS-1:0] v);
            t_result     r;
            int unsigned ch;
            int unsigned k;
            int unsigned avg;
            r = '0;
            case (op)
                OP_SAMPLE: begin
                    // A scan cut short by a mask change resumes at the next enabled channel at
                    // or above the scan position, else at the lowest, without moving the slot.
                    ch = first_enabled(scan_pos);
                    if (ch >= CHANNELS) ch = first_enabled(0);
                    if (ch < CHANNELS) begin
                        k = ch * SAMPLES + slot;
                        sums[ch] = sums[ch] - hist[k] + v;
                        hist[k] = v;
                        r.channel_out   = ch[CHAN_BITS-1:0];
                        r.sample_echo   = v;
                        r.channel_valid = 1'b1;
                        if (first_enabled(ch + 1) >= CHANNELS) begin
                            scan_pos = 0;
                            if (slot == SAMPLES - 1) begin
                                slot         = 0;
                                batch_flag   = 1'b1;
                                r.batch_done = 1'b1;
                            end else begin
                                slot = slot + 1;
                            end
                        end else begin
                            scan_pos = ch + 1;
                        end
                    end
                end
                OP_PRESET: begin
                    foreach (hist[i]) hist[i] = v;
                    foreach (sums[i]) sums[i] = v * SAMPLES;
                end
                OP_READ: begin
                    r.channel_out = chan;
                    if (mask[chan]) begin
                        avg = sums[chan] / SAMPLES;
                        r.average = avg[OUT_BITS-1:0];
                    end
                end
                default: begin
                    r.batch_done = batch_flag;
                    batch_flag   = 1'b0;
                end
            endcase
            owed_results.push_back(r);
        endfunction

        task flag_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        task match_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                flag_mismatch("result beat with nothing owed", got, 0);
            end else begin
                want = owed_results.pop_front();
                if (got.channel_out !== want.channel_out)
                    flag_mismatch("channel_out", got.channel_out, want.channel_out);
                if (got.average !== want.average)
                    flag_mismatch("average", got.average, want.average);
                if (got.sample_echo !== want.sample_echo)
                    flag_mismatch("sample_echo", got.sample_echo, want.sample_echo);
                if (got.channel_valid !== want.channel_valid)
                    flag_mismatch("channel_valid", got.channel_valid, want.channel_valid);
                if (got.batch_done !== want.batch_done)
                    flag_mismatch("batch_done", got.batch_done, want.batch_done);
            end
        endtask
    endclass

    // The clock starts low before any process runs, so time zero sees no edge.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [MASK_BITS-1:0] i_cfg_wdata;

    asca_in_if  conv_if ();
    asca_out_if res_if ();

    adc_scan_channel_averager_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (conv_if),
        .o_out       (res_if)
    );

    boxcar_tracker tracker = new();

    // Percent of cycles in which the sender holds back a beat and in which
    // the receiver refuses one. The main sequence changes them between groups of phases.
    int send_idle_pct = 26;
    int recv_idle_pct = 69;
    int cycles        = 0;

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        conv_if.valid   = 1'b0;
        conv_if.op      = '0;
        conv_if.channel = '0;
        conv_if.value   = '0;
        res_if.ready    = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // The receiver decides its ready for the coming edge at each falling edge.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are watched at the rising edge, where a beat moves when
    // valid and ready are high together.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (conv_if.valid && conv_if.ready)
                tracker.take_beat(t_op'(conv_if.op), conv_if.channel, conv_if.value);
            if (res_if.valid && res_if.ready) begin
                got.channel_out   = res_if.channel_out;
                got.average       = res_if.average;
                got.sample_echo   = res_if.sample_echo;
                got.channel_valid = res_if.channel_valid;
                got.batch_done    = res_if.batch_done;
                tracker.match_result(got);
            end
        end
    end

    // Watchdog for a block that stops answering.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("adc_scan_channel_averager_unit test failed");
            $finish;
        end
    end

    // Offers one input beat and returns at the falling edge after it was
    // taken, with valid still high. Must be called at a falling edge.
    task automatic send_beat(t_op op, logic [CHAN_BITS-1:0] ch, logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            conv_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        conv_if.valid   <= 1'b1;
        conv_if.op      <= op;
        conv_if.channel <= ch;
        conv_if.value   <= v;
        do @(posedge i_clk); while (!conv_if.ready);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed result has come back. It always
    // waits for a falling edge first, so valid is never lowered and raised in
    // the same step.
    task automatic wait_drain();
        conv_if.valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.owed() != 0) @(negedge i_clk);
    endtask

    // The mask is only changed with the block idle.
    task automatic write_mask(logic [MASK_BITS-1:0] m);
        wait_drain();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_mask(m);
    endtask

    // Mostly random values, with the two extremes showing up often.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // One random phase. Most beats are conversions so scans complete and
    // slots wrap; reads, polls and the rare preset are mixed in.
    task automatic play_phase(logic [MASK_BITS-1:0] m, int beats);
        int pick;
        write_mask(m);
        for (int n = 0; n < beats; n++) begin
            // Now and then the sender holds off until the block has caught up.
            if (n == beats / 2 || $urandom_range(63) == 0) wait_drain();
            pick = $urandom_range(99);
            if (pick < 2)
                send_beat(OP_PRESET, CHAN_BITS'($urandom), pick_value());
            else if (pick < 16)
                send_beat(OP_READ, CHAN_BITS'($urandom), VALUE_BITS'($urandom));
            else if (pick < 26)
                send_beat(OP_POLL, CHAN_BITS'($urandom), VALUE_BITS'($urandom));
            else
                send_beat(OP_SAMPLE, CHAN_BITS'($urandom), pick_value());
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. With no channel enabled a conversion files nothing,
        // a read gives zero and a poll finds the flag clear.
        send_beat(OP_SAMPLE, 4'd0, 10'd1023);
        send_beat(OP_READ, 4'd0, 10'd0);
        send_beat(OP_POLL, 4'd0, 10'd0);
        send_beat(OP_PRESET, 4'd15, 10'd1023);

        // All channels on: the preset mean shows on the top channel, and a
        // partial scan leaves the scan position in the middle.
        write_mask(16'hffff);
        send_beat(OP_READ, 4'd15, 10'd0);
        send_beat(OP_SAMPLE, 4'd0, 10'd0);
        send_beat(OP_SAMPLE, 4'd5, 10'd1023);
        send_beat(OP_SAMPLE, 4'd0, 10'd512);
        send_beat(OP_READ, 4'd0, 10'd1023);
        send_beat(OP_READ, 4'd1, 10'd0);
        send_beat(OP_POLL, 4'd0, 10'd0);

        // Only the top channel on, changed in mid scan. Eight conversions,
        // each a full scan, make the slot wrap once; the first poll sees the
        // batch flag, the second finds it cleared.
        write_mask(16'h8000);
        for (int n = 0; n < SAMPLES; n++) send_beat(OP_SAMPLE, 4'd0, 10'(n * 146));
        send_beat(OP_POLL, 4'd0, 10'd0);
        send_beat(OP_POLL, 4'd0, 10'd0);
        send_beat(OP_READ, 4'd15, 10'd0);

        // Random phases: sender idles less than the receiver, then the other
        // way round, then neither idles.
        play_phase(16'hffff, PHASE_BEATS);
        play_phase(16'h0001, PHASE_BEATS);
        play_phase(MASK_BITS'($urandom), PHASE_BEATS);
        send_idle_pct = 69;
        recv_idle_pct = 26;
        play_phase(16'h8000, PHASE_BEATS);
        play_phase(MASK_BITS'($urandom & $urandom & $urandom), PHASE_BEATS);
        play_phase(16'h0000, PHASE_BEATS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        play_phase(MASK_BITS'($urandom), PHASE_BEATS);
        play_phase(16'hffff, PHASE_BEATS);

        wait_drain();
        repeat (SETTLE_TICKS) @(negedge i_clk);

        if (tracker.mismatches == 0 && tracker.owed() == 0) begin
            $display("adc_scan_channel_averager_unit test passed");
        end else begin
            $display("adc_scan_channel_averager_unit test failed");
        end
        $finish;
    end
endmodule

@@ adc_scan_channel_averager_unit.f @@
+incdir+src
src/asca_pkg.sv
src/asca_ifs.sv
src/asca_scan.sv
src/adc_scan_channel_averager_unit.sv
verif/tb.sv
